@@ sv/cwt_pkg.sv @@
package cwt_pkg;

  localparam int unsigned COS_TABLE_DEPTH_DEF = 1024;

  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // cosine rom generation, Q2.30 Taylor series
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] TAYLOR_DIV [9] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306
  };

  localparam logic [1:0] REG_CORNER_ONE   = 2'd0;
  localparam logic [1:0] REG_CORNER_TWO   = 2'd1;
  localparam logic [1:0] REG_CORNER_THREE = 2'd2;
  localparam logic [1:0] REG_CORNER_FOUR  = 2'd3;

  localparam logic signed [31:0] CORNER_ONE_RST   = 32'sd0;
  localparam logic signed [31:0] CORNER_TWO_RST   = 32'sd32768;
  localparam logic signed [31:0] CORNER_THREE_RST = 32'sd32768;
  localparam logic signed [31:0] CORNER_FOUR_RST  = 32'sd65536;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_ONE,
    MODE_EDGE
  } mode_e;

  typedef struct packed {
    logic  valid;
    mode_e mode;
  } ctl_t;

  localparam ctl_t CTL_IDLE = '{valid: 1'b0, mode: MODE_ZERO};

  typedef struct packed {
    logic signed [31:0] corner_one;
    logic signed [31:0] corner_two;
    logic signed [31:0] corner_three;
    logic signed [31:0] corner_four;
  } cfg_t;

endpackage

@@ sv/cosine_taper_window.sv @@
// datapath registers in order: front stages a and b, one per divider stage, then back stages c, d and e
// throughput: one item per cycle while the output is not stalled, set by the pipelined divider that resolves one phase
// bit per stage, followed by a registered cosine rom read
// a stall on a valid output holds the whole pipeline in place
// reset clears all pipeline valid bits and loads the corner registers with their reset values
module cosine_taper_window #(
  parameter int unsigned COS_TABLE_DEPTH = cwt_pkg::COS_TABLE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        weight_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cwt_pkg::*;

  localparam int unsigned SPAN = 2 * COS_TABLE_DEPTH;
  localparam int unsigned SW   = $clog2(SPAN + 1);
  localparam int unsigned QW   = $clog2(SPAN);
  localparam int unsigned NW   = 32 + SW;

  cfg_t          cfg;
  logic          en;
  ctl_t          front_ctl, div_ctl;
  logic [NW-1:0] front_prod;
  logic [31:0]   front_den, div_rem, div_den;
  logic [QW-1:0] div_quo;

  // pipeline moves whenever the output register is free or being drained
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  cwt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cwt_front #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .position_i (position_i),
    .cfg_i      (cfg),
    .ctl_o      (front_ctl),
    .prod_o     (front_prod),
    .den_o      (front_den)
  );

  cwt_divider #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (front_ctl),
    .prod_i (front_prod),
    .den_i  (front_den),
    .ctl_o  (div_ctl),
    .quo_o  (div_quo),
    .rem_o  (div_rem),
    .den_o  (div_den)
  );

  cwt_back #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (div_ctl),
    .quo_i    (div_quo),
    .rem_i    (div_rem),
    .den_i    (div_den),
    .valid_o  (out_valid_o),
    .weight_o (weight_o)
  );

endmodule

@@ sv/cwt_regs.sv @@
module cwt_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cwt_pkg::cfg_t cfg_o
);
  import cwt_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.corner_one   <= CORNER_ONE_RST;
      cfg_q.corner_two   <= CORNER_TWO_RST;
      cfg_q.corner_three <= CORNER_THREE_RST;
      cfg_q.corner_four  <= CORNER_FOUR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CORNER_ONE:   cfg_q.corner_one   <= pwdata;
        REG_CORNER_TWO:   cfg_q.corner_two   <= pwdata;
        REG_CORNER_THREE: cfg_q.corner_three <= pwdata;
        REG_CORNER_FOUR:  cfg_q.corner_four  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CORNER_ONE:   prdata = cfg_q.corner_one;
      REG_CORNER_TWO:   prdata = cfg_q.corner_two;
      REG_CORNER_THREE: prdata = cfg_q.corner_three;
      REG_CORNER_FOUR:  prdata = cfg_q.corner_four;
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/cwt_front.sv @@
module cwt_front #(
  parameter int unsigned COS_TABLE_DEPTH = cwt_pkg::COS_TABLE_DEPTH_DEF,
  localparam int unsigned SPAN = 2 * COS_TABLE_DEPTH,
  localparam int unsigned SW   = $clog2(SPAN + 1),
  localparam int unsigned NW   = 32 + SW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] position_i,
  input  cwt_pkg::cfg_t      cfg_i,
  output cwt_pkg::ctl_t      ctl_o,
  output logic [NW-1:0]      prod_o,
  output logic [31:0]        den_o
);
  import cwt_pkg::*;

  // stage a: classify and form the edge fraction
  logic        le_c1, ge_c4, in_top, lt_c2;
  logic [32:0] rise_num, rise_den, fall_num, fall_den;
  ctl_t        ctl_a_d, ctl_a_q;
  logic [31:0] num_a_d, num_a_q, den_a_d, den_a_q;

  assign le_c1  = position_i <= cfg_i.corner_one;
  assign ge_c4  = position_i >= cfg_i.corner_four;
  assign lt_c2  = position_i < cfg_i.corner_two;
  assign in_top = !lt_c2 && (position_i <= cfg_i.corner_three);

  assign rise_num = {position_i[31], position_i}
                  - {cfg_i.corner_one[31], cfg_i.corner_one};
  assign rise_den = {cfg_i.corner_two[31], cfg_i.corner_two}
                  - {cfg_i.corner_one[31], cfg_i.corner_one};
  assign fall_num = {cfg_i.corner_four[31], cfg_i.corner_four}
                  - {position_i[31], position_i};
  assign fall_den = {cfg_i.corner_four[31], cfg_i.corner_four}
                  - {cfg_i.corner_three[31], cfg_i.corner_three};

  always_comb begin
    ctl_a_d.valid = valid_i;
    if (le_c1 || ge_c4) begin
      ctl_a_d.mode = MODE_ZERO;
    end else if (in_top) begin
      ctl_a_d.mode = MODE_ONE;
    end else begin
      ctl_a_d.mode = MODE_EDGE;
    end
    if (lt_c2) begin
      num_a_d = rise_num[31:0];
      den_a_d = rise_den[31:0];
    end else begin
      num_a_d = fall_num[31:0];
      den_a_d = fall_den[31:0];
    end
  end

  // stage b: scale the numerator by the phase span
  ctl_t          ctl_b_q;
  logic [NW-1:0] prod_b_q;
  logic [31:0]   den_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= CTL_IDLE;
      ctl_b_q <= CTL_IDLE;
    end else if (en_i) begin
      ctl_a_q <= ctl_a_d;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_a_q  <= num_a_d;
      den_a_q  <= den_a_d;
      prod_b_q <= NW'(num_a_q) * NW'(SPAN);
      den_b_q  <= den_a_q;
    end
  end

  assign ctl_o  = ctl_b_q;
  assign prod_o = prod_b_q;
  assign den_o  = den_b_q;

endmodule

@@ sv/cwt_divider.sv @@
module cwt_divider #(
  parameter int unsigned COS_TABLE_DEPTH = cwt_pkg::COS_TABLE_DEPTH_DEF,
  localparam int unsigned SPAN = 2 * COS_TABLE_DEPTH,
  localparam int unsigned SW   = $clog2(SPAN + 1),
  localparam int unsigned QW   = $clog2(SPAN),
  localparam int unsigned NW   = 32 + SW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  cwt_pkg::ctl_t ctl_i,
  input  logic [NW-1:0] prod_i,
  input  logic [31:0]   den_i,
  output cwt_pkg::ctl_t ctl_o,
  output logic [QW-1:0] quo_o,
  output logic [31:0]   rem_o,
  output logic [31:0]   den_o
);
  import cwt_pkg::*;

  // restoring division, one quotient bit per stage, msb first
  ctl_t          ctl_q [QW];
  logic [NW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [31:0]   den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    ctl_t          ctl_in;
    logic [NW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [31:0]   den_in;
    logic [NW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign rem_in = prod_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign ctl_in = ctl_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = NW'(den_in) << (QW - 1 - k);
    assign take  = rem_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= CTL_IDLE;
      end else if (en_i) begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? rem_in - trial : rem_in;
        quo_q[k] <= quo_in | (QW'(take) << (QW - 1 - k));
        den_q[k] <= den_in;
      end
    end
  end

  assign ctl_o = ctl_q[QW-1];
  assign quo_o = quo_q[QW-1];
  assign rem_o = rem_q[QW-1][31:0];
  assign den_o = den_q[QW-1];

endmodule

@@ sv/cwt_back.sv @@
module cwt_back #(
  parameter int unsigned COS_TABLE_DEPTH = cwt_pkg::COS_TABLE_DEPTH_DEF,
  localparam int unsigned SPAN = 2 * COS_TABLE_DEPTH,
  localparam int unsigned SW   = $clog2(SPAN + 1),
  localparam int unsigned QW   = $clog2(SPAN),
  localparam int unsigned IW   = $clog2(COS_TABLE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  cwt_pkg::ctl_t ctl_i,
  input  logic [QW-1:0] quo_i,
  input  logic [31:0]   rem_i,
  input  logic [31:0]   den_i,
  output logic          valid_o,
  output logic [15:0]   weight_o
);
  import cwt_pkg::*;

  typedef logic [15:0] rom_t [COS_TABLE_DEPTH + 1];

  function automatic logic [15:0] cos_entry(input int unsigned k);
    logic [63:0] theta;
    logic [63:0] theta2;
    logic [63:0] term;
    logic [63:0] q;
    longint      sum;
    theta  = (PI_Q30 * 64'(k)) / 64'(SPAN);
    theta2 = (theta * theta) >> 30;
    term   = ONE_Q30;
    sum    = longint'(ONE_Q30);
    for (int n = 1; n <= 9; n++) begin
      term = ((term * theta2) >> 30) / TAYLOR_DIV[n-1];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    q = (64'(sum) + 64'd16384) >> 15;
    if (q > 64'(ONE_Q15)) q = 64'(ONE_Q15);
    return q[15:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= int'(COS_TABLE_DEPTH); k++) begin
      r[k] = cos_entry(k);
    end
    return r;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  // stage c: round the phase and fold it onto the quarter wave
  logic [SW-1:0] phase_raw, phase;
  logic          round_up;
  logic [IW-1:0] idx_d, idx_q;
  logic          neg_d, neg_c_q;
  ctl_t          ctl_c_q;

  assign round_up  = {rem_i, 1'b0} >= {1'b0, den_i};
  assign phase_raw = SW'(quo_i) + SW'(round_up);
  assign phase     = (phase_raw > SW'(SPAN)) ? SW'(SPAN) : phase_raw;

  always_comb begin
    if (phase <= SW'(COS_TABLE_DEPTH)) begin
      idx_d = phase[IW-1:0];
      neg_d = 1'b0;
    end else begin
      idx_d = IW'(SW'(SPAN) - phase);
      neg_d = 1'b1;
    end
  end

  // stage d: rom read
  logic [15:0] cos_q;
  logic        neg_d_q;
  ctl_t        ctl_d_q;

  // stage e: weight = (1 - cos) / 2, half up
  logic [17:0] half_sum;
  logic [15:0] weight_d, weight_q;
  logic        valid_q;

  always_comb begin
    if (neg_d_q) begin
      half_sum = 18'(ONE_Q15) + 18'(cos_q) + 18'd1;
    end else begin
      half_sum = 18'(ONE_Q15) - 18'(cos_q) + 18'd1;
    end
    case (ctl_d_q.mode)
      MODE_ZERO: weight_d = '0;
      MODE_ONE:  weight_d = ONE_Q15;
      MODE_EDGE: weight_d = half_sum[16:1];
      default:   weight_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c_q <= CTL_IDLE;
      ctl_d_q <= CTL_IDLE;
      valid_q <= 1'b0;
    end else if (en_i) begin
      ctl_c_q <= ctl_i;
      ctl_d_q <= ctl_c_q;
      valid_q <= ctl_d_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q    <= idx_d;
      neg_c_q  <= neg_d;
      cos_q    <= COS_ROM[idx_q];
      neg_d_q  <= neg_c_q;
      weight_q <= weight_d;
    end
  end

  assign valid_o  = valid_q;
  assign weight_o = weight_q;

endmodule

@@ sv/cwt_checker.sv @@
module cwt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] weight_o,
  input logic        pready
);
  import cwt_pkg::*;

  // a result waiting on a stall holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(weight_o))
    else $error("stalled result changed");

  // weight never exceeds one in Q1.15
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> weight_o <= ONE_Q15)
    else $error("weight above one");

  // input side only stalls while a result is held back
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall without output stall");

  // an input offered while the output is held keeps the output valid
  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> out_valid_o)
    else $error("output dropped while input stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind cosine_taper_window cwt_checker u_checker (.*);

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD     = 8;
  localparam int unsigned COS_DEPTH      = cwt_pkg::COS_TABLE_DEPTH_DEF;
  localparam int          LATENCY        = $clog2(2 * COS_DEPTH) + 5;
  localparam int          LONG_HOLD      = 120;
  localparam int          TIMEOUT_CYCLES = 200000;

  localparam longint unsigned PI_Q30     = 64'd3373259426;
  localparam longint unsigned ONE_Q30    = 64'd1073741824;
  localparam longint          WEIGHT_ONE = 64'sd32768;
  localparam longint          POS_MAX    = 64'sd2147483647;
  localparam longint          POS_MIN    = -64'sd2147483648;

  localparam logic signed [31:0] RESET_PROBES [13] = '{
    32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd1, 32'd16384, 32'd32767,
    32'd32768, 32'd32769, 32'd49152, 32'd65535, 32'd65536, 32'd65537
  };

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY,
    STALL_PATTERN
  } stall_mode_e;

  class taper_scoreboard;
    typedef struct {
      logic signed [31:0] position;
      logic [15:0]        weight;
    } weight_exp_t;

    longint       corner [4];
    logic [15:0]  cos_table [COS_DEPTH + 1];
    weight_exp_t  expected_weights [$];
    int unsigned  errors;

    function new();
      longint unsigned theta;
      longint unsigned theta2;
      longint unsigned term;
      longint unsigned q;
      longint          sum;
      int              k;
      int              n;
      errors = 0;
      corner[cwt_pkg::REG_CORNER_ONE]   = 0;
      corner[cwt_pkg::REG_CORNER_TWO]   = 32768;
      corner[cwt_pkg::REG_CORNER_THREE] = 32768;
      corner[cwt_pkg::REG_CORNER_FOUR]  = 65536;
      // quarter-wave cosine, Q2.30 taylor series rounded to Q1.15
      for (k = 0; k <= COS_DEPTH; k++) begin
        theta  = (PI_Q30 * k) / (2 * COS_DEPTH);
        theta2 = (theta * theta) >> 30;
        term   = ONE_Q30;
        sum    = ONE_Q30;
        for (n = 1; n <= 9; n++) begin
          term = ((term * theta2) >> 30) / ((2 * n - 1) * (2 * n));
          if (n % 2 == 1) sum -= term;
          else sum += term;
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(ONE_Q30)) sum = ONE_Q30;
        q = (sum + 16384) >> 15;
        if (q > 32768) q = 32768;
        cos_table[k] = q[15:0];
      end
    endfunction

    function void set_corner(input logic [1:0] idx, input logic signed [31:0] value);
      corner[idx] = value;
    endfunction

    function int pending();
      return expected_weights.size();
    endfunction

    function logic [15:0] edge_weight(input longint unsigned num, input longint unsigned den);
      longint unsigned span;
      longint unsigned phase;
      longint          cosv;
      span  = 2 * COS_DEPTH;
      phase = (num * span * 2 + den) / (2 * den);
      if (phase > span) phase = span;
      // second quadrant mirrors the table with a sign flip
      if (phase <= COS_DEPTH) cosv = cos_table[phase];
      else cosv = -longint'(cos_table[span - phase]);
      return 16'((WEIGHT_ONE - cosv + 1) >>> 1);
    endfunction

    function logic [15:0] predict_weight(input logic signed [31:0] x);
      longint px;
      px = x;
      if (px <= corner[cwt_pkg::REG_CORNER_ONE]) return 16'd0;
      if (px >= corner[cwt_pkg::REG_CORNER_FOUR]) return 16'd0;
      if (px >= corner[cwt_pkg::REG_CORNER_TWO] && px <= corner[cwt_pkg::REG_CORNER_THREE])
        return 16'(WEIGHT_ONE);
      if (px < corner[cwt_pkg::REG_CORNER_TWO])
        return edge_weight(px - corner[cwt_pkg::REG_CORNER_ONE],
                           corner[cwt_pkg::REG_CORNER_TWO] - corner[cwt_pkg::REG_CORNER_ONE]);
      return edge_weight(corner[cwt_pkg::REG_CORNER_FOUR] - px,
                         corner[cwt_pkg::REG_CORNER_FOUR] - corner[cwt_pkg::REG_CORNER_THREE]);
    endfunction

    function void note_position(input logic signed [31:0] x);
      weight_exp_t e;
      e.position = x;
      e.weight   = predict_weight(x);
      expected_weights.push_back(e);
    endfunction

    task report(input string what);
      if (errors < 50) $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_weight(input logic [15:0] got);
      weight_exp_t e;
      if (expected_weights.size() == 0) begin
        report($sformatf("weight %0d with no transfer outstanding", got));
      end else begin
        e = expected_weights.pop_front();
        if (got !== e.weight)
          report($sformatf("position %0d: weight %0d, expected %0d", e.position, got, e.weight));
      end
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] position_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [15:0]        weight_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [3:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  stall_mode_e stall_mode    = STALL_NONE;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  logic [15:0] stall_pattern = 16'b0011_0100_0111_0001;

  taper_scoreboard sb;

  cosine_taper_window #(
    .COS_TABLE_DEPTH(COS_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .weight_o   (weight_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // output side stall: long hold on request, otherwise the phase's pattern
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:   out_stall_i <= 1'b0;
        STALL_RANDOM: out_stall_i <= ($urandom_range(0, 9) < 3);
        STALL_HEAVY:  out_stall_i <= ($urandom_range(0, 9) < 7);
        default: begin
          out_stall_i   <= stall_pattern[0];
          stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_position(position_i);
      if (out_valid_o && !out_stall_i) sb.check_weight(weight_o);
    end
  end

  task automatic write_corner(input logic [1:0] idx, input logic signed [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_corner(idx, value);
    @(posedge clk_i);
  endtask

  task automatic set_corners(input logic signed [31:0] c1, input logic signed [31:0] c2,
                             input logic signed [31:0] c3, input logic signed [31:0] c4);
    write_corner(cwt_pkg::REG_CORNER_ONE, c1);
    write_corner(cwt_pkg::REG_CORNER_TWO, c2);
    write_corner(cwt_pkg::REG_CORNER_THREE, c3);
    write_corner(cwt_pkg::REG_CORNER_FOUR, c4);
  endtask

  task automatic load_random_corners(input bit ordered);
    logic signed [31:0] picks [$];
    logic signed [31:0] v;
    repeat (4) begin
      if ($urandom_range(0, 2) == 0) v = $urandom;
      else v = $urandom_range(0, 400000) - 200000;
      picks.push_back(v);
    end
    if (ordered) picks.sort();
    set_corners(picks[0], picks[1], picks[2], picks[3]);
  endtask

  function automatic logic signed [31:0] random_position();
    longint          v;
    longint          lo;
    longint          hi;
    longint unsigned span;
    int              pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // right around a corner
      v = sb.corner[$urandom_range(0, 3)] + longint'($urandom_range(0, 6)) - 3;
      if (v > POS_MAX) v = POS_MAX;
      if (v < POS_MIN) v = POS_MIN;
    end else if (pick < 80) begin
      lo = sb.corner[0];
      hi = sb.corner[0];
      foreach (sb.corner[i]) begin
        if (sb.corner[i] < lo) lo = sb.corner[i];
        if (sb.corner[i] > hi) hi = sb.corner[i];
      end
      span = hi - lo;
      v = lo + longint'({$urandom, $urandom} % (span + 1));
    end else if (pick < 92) begin
      v = longint'(signed'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0:       v = POS_MIN;
        1:       v = POS_MAX;
        2:       v = -1;
        default: v = 0;
      endcase
    end
    return v[31:0];
  endfunction

  task automatic send_position(input logic signed [31:0] x);
    in_valid_i <= 1'b1;
    position_i <= x;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_items, input stall_mode_e mode, input bit gapless,
                           input bit hold_output, input bit pause_midway);
    int burst_left;
    int gap;
    int i;
    burst_left = 0;
    stall_mode <= mode;
    if (hold_output) hold_requests <= hold_requests + 1;
    for (i = 0; i < n_items; i++) begin
      if (pause_midway && i == n_items / 2) begin
        // let the pipeline run dry before going on
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end else if (burst_left == 0 && !gapless) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      send_position(random_position());
      if (burst_left > 0) burst_left--;
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset corners: boundaries, edge midpoints and field extremes
    foreach (RESET_PROBES[i]) send_position(RESET_PROBES[i]);
    run_phase(50, STALL_RANDOM, 1'b0, 1'b0, 1'b0);

    set_corners(32'h8000_0000, -32'sd65536, 32'sd65536, 32'h7fff_ffff);
    run_phase(55, STALL_NONE, 1'b1, 1'b0, 1'b0);

    // widest possible rising edge
    set_corners(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    run_phase(45, STALL_PATTERN, 1'b0, 1'b0, 1'b0);

    // one-step edges, output held off while input keeps coming
    set_corners(-32'sd5, -32'sd4, 32'sd3, 32'sd4);
    run_phase(50, STALL_HEAVY, 1'b0, 1'b1, 1'b0);

    // disordered corners fall through to the falling edge
    set_corners(32'sd200000, 32'sd100000, -32'sd100000, 32'sd300000);
    run_phase(50, STALL_RANDOM, 1'b0, 1'b0, 1'b1);

    // rectangle: both edges empty
    set_corners(32'sd1000, 32'sd1000, 32'sd5000, 32'sd5000);
    run_phase(45, STALL_PATTERN, 1'b0, 1'b0, 1'b0);

    set_corners(-32'sd196608, -32'sd65536, 32'sd65536, 32'sd327680);
    run_phase(60, STALL_RANDOM, 1'b0, 1'b0, 1'b0);

    load_random_corners(1'b1);
    run_phase(50, STALL_NONE, 1'b0, 1'b0, 1'b0);
    load_random_corners(1'b1);
    run_phase(50, STALL_HEAVY, 1'b0, 1'b0, 1'b0);
    load_random_corners(1'b0);
    run_phase(45, STALL_RANDOM, 1'b0, 1'b0, 1'b0);

    if (sb.errors == 0) begin
      $display("PASS cosine_taper_window");
    end else begin
      $display("FAIL cosine_taper_window");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL cosine_taper_window");
    $finish;
  end

endmodule
